// ----- design/fifo_with_prefix_reverse_macros.svh -----
// Assertion macros shared by the queue block
`ifndef FIFO_WITH_PREFIX_REVERSE_MACROS_SVH
`define FIFO_WITH_PREFIX_REVERSE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FWPR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FWPR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`else

`define FWPR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define FWPR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)

`endif

`endif

// ----- design/fwpr_pkg.sv -----
package fwpr_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int K_W      = 8;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REV = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_EMPTY,
    RES_FULL,
    RES_DEQ
  } res_kind_t;

  typedef struct packed {
    logic      enq;
    logic      deq_rd;
    logic      deq_pop;
    logic      rev_init;
    logic      sw_rd;
    logic      sw_wa;
    logic      sw_wb;
    res_kind_t res;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic trivial;
    logic last_pair;
  } stat_t;

endpackage

// ----- design/fwpr_ctrl.sv -----
`include "fifo_with_prefix_reverse_macros.svh"

module fwpr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fwpr_pkg::OP_W-1:0]     op,
  input  fwpr_pkg::stat_t               stat,
  output logic                          busy,
  output fwpr_pkg::cmd_t                cmd
);
  import fwpr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_ENQ: begin
              if (stat.full) begin
                cmd.res = RES_FULL;
              end else begin
                cmd.enq = 1'b1;
                cmd.res = RES_OK;
              end
            end
            OP_DEQ: begin
              if (stat.empty) begin
                cmd.res = RES_EMPTY;
              end else begin
                cmd.deq_rd = 1'b1;
                state_next = S_DEQ;
              end
            end
            OP_REV: begin
              if (stat.trivial) begin
                cmd.res = RES_OK;
              end else begin
                cmd.rev_init = 1'b1;
                state_next   = S_SWAP_RD;
              end
            end
            default: begin
              cmd.res = RES_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.deq_pop = 1'b1;
        cmd.res     = RES_DEQ;
        state_next  = S_IDLE;
      end
      S_SWAP_RD: begin
        cmd.sw_rd  = 1'b1;
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd.sw_wa  = 1'b1;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd.sw_wb = 1'b1;
        if (stat.last_pair) begin
          cmd.res    = RES_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_SWAP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  `FWPR_ASSERT_NXT(a_deq_ret, clk, rst, state == S_DEQ, state == S_IDLE, "dequeue overran")
  `FWPR_ASSERT_NXT(a_wb_loop, clk, rst, (state == S_SWAP_WB) && !stat.last_pair, state == S_SWAP_RD, "swap loop ended early")
  `FWPR_ASSERT_NXT(a_rev_go, clk, rst, (state == S_IDLE) && start && (op == OP_REV) && !stat.trivial, state == S_SWAP_RD, "reverse not started")

endmodule

// ----- design/fwpr_dp.sv -----
`include "fifo_with_prefix_reverse_macros.svh"

module fwpr_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fwpr_pkg::cmd_t                       cmd,
  input  logic signed [fwpr_pkg::VALUE_W-1:0]  value,
  input  logic [fwpr_pkg::K_W-1:0]             k,
  output fwpr_pkg::stat_t                      stat,
  output logic                                 done,
  output logic signed [fwpr_pkg::VALUE_W-1:0]  value_out,
  output logic [fwpr_pkg::STATUS_W-1:0]        status,
  output logic [$clog2(DEPTH+1)-1:0]           occupancy
);
  import fwpr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int NW = (CW > K_W) ? CW : K_W;
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_X = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [PW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [PW-1:0]      pa;
  logic [PW-1:0]      pb;
  logic [CW-1:0]      remaining;
  logic [VALUE_W-1:0] rdata_a;
  logic [VALUE_W-1:0] rdata_b;

  logic [SW-1:0]      tail_sum;
  logic [PW-1:0]      tail;
  logic [NW-1:0]      k_x;
  logic [NW-1:0]      cnt_x;
  logic [CW-1:0]      n;
  logic [SW-1:0]      pb_sum;
  logic [PW-1:0]      pb_init;
  logic [PW-1:0]      head_inc;
  logic [PW-1:0]      pa_inc;
  logic [PW-1:0]      pb_dec;
  logic               we;
  logic [PW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [PW-1:0]      raddr_a;

  always_comb begin
    tail_sum = SW'(head) + SW'(count);
    tail     = (tail_sum >= DEPTH_X) ? PW'(tail_sum - DEPTH_X) : PW'(tail_sum);
    k_x      = NW'(k);
    cnt_x    = NW'(count);
    n        = (k_x < cnt_x) ? CW'(k_x) : count;
    pb_sum   = SW'(head) + SW'(n) - SW'(1);
    pb_init  = (pb_sum >= DEPTH_X) ? PW'(pb_sum - DEPTH_X) : PW'(pb_sum);
    head_inc = (head == LAST_P) ? '0 : head + PW'(1);
    pa_inc   = (pa == LAST_P) ? '0 : pa + PW'(1);
    pb_dec   = (pb == '0) ? LAST_P : pb - PW'(1);
  end

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CW'(1);
    end else if (cmd.deq_pop) begin
      count_next = count - CW'(1);
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == DEPTH_C);
  assign stat.trivial   = (n < CW'(2));
  assign stat.last_pair = (remaining == CW'(1));

  always_comb begin
    we    = cmd.enq | cmd.sw_wa | cmd.sw_wb;
    waddr = tail;
    wdata = value;
    if (cmd.sw_wa) begin
      waddr = pa;
      wdata = rdata_b;
    end else if (cmd.sw_wb) begin
      waddr = pb;
      wdata = rdata_a;
    end
    raddr_a = cmd.deq_rd ? head : pa;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deq_rd | cmd.sw_rd) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[pb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      remaining <= '0;
    end else begin
      count <= count_next;
      if (cmd.deq_pop) begin
        head <= head_inc;
      end
      if (cmd.rev_init) begin
        remaining <= n >> 1;
      end else if (cmd.sw_wb) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rev_init) begin
      pa <= head;
      pb <= pb_init;
    end else if (cmd.sw_wb) begin
      pa <= pa_inc;
      pb <= pb_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res != RES_NONE) begin
      occupancy <= count_next;
      case (cmd.res)
        RES_DEQ: begin
          value_out <= rdata_a;
          status    <= STATUS_OK;
        end
        RES_EMPTY: begin
          value_out <= '1;
          status    <= STATUS_EMPTY;
        end
        RES_FULL: begin
          value_out <= '0;
          status    <= STATUS_FULL;
        end
        default: begin
          value_out <= '0;
          status    <= STATUS_OK;
        end
      endcase
    end
  end

  `FWPR_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= DEPTH_C, "count beyond depth")
  `FWPR_ASSERT_IMP(a_enq_room, clk, rst, cmd.enq, !stat.full, "write into full ring")
  `FWPR_ASSERT_IMP(a_empty_res, clk, rst, done && (status == STATUS_EMPTY), (value_out == '1) && (occupancy == '0), "bad empty result")

endmodule

// ----- design/fifo_with_prefix_reverse.sv -----
// Queue of signed 32-bit values with enqueue, dequeue and reverse-first-k.
// Command channel: op, value and k are taken at a rising edge where start is
// high and busy is low. Result channel: done is high for exactly one cycle
// with value_out, status and occupancy; the transfer completes at the end of
// that cycle and the receiver cannot stall it.
// Enqueue, failed dequeue, trivial reverse and unused op give their result
// in the cycle after the transfer and busy stays low, so these go one per
// cycle. A dequeue reads the ring memory into a register at the transfer,
// then pops the entry in S_DEQ with busy high. A reverse of n = min(k,
// occupancy) entries swaps pairs from the ends inward: each swap reads both
// slots on both read ports in S_SWAP_RD, then writes them back in S_SWAP_WA
// and S_SWAP_WB through the single write port. Its result follows one cycle
// after the last swap, and the next command may be taken that cycle.
// Reset clears head, entry count and controller; slots keep their contents.
module fifo_with_prefix_reverse #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [fwpr_pkg::OP_W-1:0]            op,
  input  logic signed [fwpr_pkg::VALUE_W-1:0]  value,
  input  logic [fwpr_pkg::K_W-1:0]             k,
  output logic                                 done,
  output logic signed [fwpr_pkg::VALUE_W-1:0]  value_out,
  output logic [fwpr_pkg::STATUS_W-1:0]        status,
  output logic [$clog2(DEPTH+1)-1:0]           occupancy
);
  import fwpr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fwpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  fwpr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .k         (k),
    .stat      (stat),
    .done      (done),
    .value_out (value_out),
    .status    (status),
    .occupancy (occupancy)
  );

endmodule

// ----- bench/fifo_with_prefix_reverse_test.sv -----
module fifo_with_prefix_reverse_test;
  import fwpr_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1525;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int QUIET_FIRST = 500;
  localparam int QUIET_LAST = 800;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [K_W-1:0]            k;
    bit                        drain;
  } queue_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
  } queue_res_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] op = OP_ENQ;
  logic signed [VALUE_W-1:0] value = '0;
  logic [K_W-1:0] k = '0;
  logic done;
  logic signed [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0] occupancy;

  queue_cmd_t pending_cmds[$];
  queue_res_t awaited_results[$];
  queue_cmd_t next_cmd;
  queue_res_t oldest;

  logic signed [VALUE_W-1:0] ring_slots[DEPTH];
  logic [3:0] ring_head = '0;
  logic [OCC_W-1:0] ring_count = '0;

  int total_cmds;
  int offered = 0;
  int transfers = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int n_enq = 0, n_deq = 0, n_rev = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, longest_rev = 0;

  fifo_with_prefix_reverse #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .value(value), .k(k),
    .done(done), .value_out(value_out), .status(status), .occupancy(occupancy)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic queue_res_t apply_queue_op(logic [OP_W-1:0] c_op,
                                                logic signed [VALUE_W-1:0] c_value,
                                                logic [K_W-1:0] c_k);
    queue_res_t r;
    int n;
    logic signed [VALUE_W-1:0] t;
    logic [3:0] a, b;
    r.value_out = '0;
    r.status = STATUS_OK;
    case (c_op)
      OP_ENQ: begin
        if (ring_count == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          ring_slots[4'(ring_head + ring_count)] = c_value;
          ring_count = ring_count + 1'b1;
        end
      end
      OP_DEQ: begin
        if (ring_count == 0) begin
          r.value_out = -1;
          r.status = STATUS_EMPTY;
        end else begin
          r.value_out = ring_slots[ring_head];
          ring_head = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
        end
      end
      OP_REV: begin
        n = int'((c_k < ring_count) ? c_k : K_W'(ring_count));
        if (n > longest_rev) longest_rev = n;
        for (int i = 0; i < n / 2; i++) begin
          a = 4'(ring_head + i);
          b = 4'(ring_head + n - 1 - i);
          t = ring_slots[a];
          ring_slots[a] = ring_slots[b];
          ring_slots[b] = t;
        end
      end
      default: ;
    endcase
    r.occupancy = ring_count;
    return r;
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] c_op, logic signed [VALUE_W-1:0] c_value,
                         logic [K_W-1:0] c_k, bit c_drain);
    queue_cmd_t c;
    c.op = c_op;
    c.value = c_value;
    c.k = c_k;
    c.drain = c_drain;
    pending_cmds.push_back(c);
  endtask

  // driver: one item on the bus until its transfer, then the next or a gap
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (transfers == offered) begin
      if (pending_cmds.size() == 0 ||
          (!(offered >= QUIET_FIRST && offered < QUIET_LAST) && $urandom_range(99) < 23) ||
          (pending_cmds[0].drain && awaited_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_cmd = pending_cmds.pop_front();
        op <= next_cmd.op;
        value <= next_cmd.value;
        k <= next_cmd.k;
        start <= 1'b1;
        offered <= offered + 1;
      end
    end
  end

  // monitor: check results in order, predict each accepted transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value_out=%0d status=%0d occupancy=%0d",
                     value_out, status, occupancy);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (value_out !== oldest.value_out || status !== oldest.status ||
              occupancy !== oldest.occupancy) begin
            if (mismatches < 10)
              $display("mismatch: expected value_out=%0d status=%0d occupancy=%0d, got %0d %0d %0d",
                       oldest.value_out, oldest.status, oldest.occupancy,
                       value_out, status, occupancy);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        oldest = apply_queue_op(op, value, k);
        awaited_results.push_back(oldest);
        transfers <= transfers + 1;
        case (op)
          OP_ENQ: n_enq++;
          OP_DEQ: n_deq++;
          OP_REV: n_rev++;
          default: n_unused++;
        endcase
        if (oldest.status == STATUS_FULL) n_full++;
        if (oldest.status == STATUS_EMPTY) n_empty++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("fifo_with_prefix_reverse_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int roll;
    bit fill_phase;
    logic [OP_W-1:0] r_op;
    logic [K_W-1:0] r_k;

    add_cmd(OP_DEQ, 0, 0, 0);
    add_cmd(OP_REV, 0, 5, 0);
    add_cmd(OP_ENQ, 32'sh7FFF_FFFF, 0, 0);
    add_cmd(OP_ENQ, 32'sh8000_0000, 0, 0);
    add_cmd(OP_ENQ, -1, 0, 0);
    add_cmd(OP_ENQ, 0, 0, 0);
    add_cmd(OP_REV, -1, 0, 0);
    add_cmd(OP_REV, 0, 8'hFF, 0);
    add_cmd(OP_UNUSED, -1, 8'hFF, 0);
    for (int i = 0; i < 12; i++)
      add_cmd(OP_ENQ, $urandom, K_W'($urandom), 0);
    add_cmd(OP_ENQ, 32'sh1234_5678, 0, 0);
    add_cmd(OP_REV, 0, 16, 0);
    add_cmd(OP_REV, 0, 15, 0);
    add_cmd(OP_DEQ, -1, 8'hFF, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // alternate filling and draining stretches so full and empty both occur
      fill_phase = ((i / 64) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < (fill_phase ? 55 : 30)) r_op = OP_ENQ;
      else if (roll < (fill_phase ? 80 : 70)) r_op = OP_DEQ;
      else if (roll < 97) r_op = OP_REV;
      else r_op = OP_UNUSED;
      r_k = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 17)) : 8'($urandom_range(0, 255));
      add_cmd(r_op, $urandom, r_k, (i == 0) || (i == 1000));
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (transfers != total_cmds || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end
    $display("%0d transfers: %0d enqueue, %0d dequeue, %0d reverse, %0d unused opcode",
             transfers, n_enq, n_deq, n_rev, n_unused);
    $display("%0d full enqueues, %0d empty dequeues, longest reverse %0d entries, %0d mismatches",
             n_full, n_empty, longest_rev, mismatches);
    if (mismatches == 0) begin
      $display("fifo_with_prefix_reverse_test: clean");
    end else begin
      $display("fifo_with_prefix_reverse_test: errors");
    end
    $finish;
  end

endmodule
